### rtl/huffman_code_bit_packer_macros.svh
// Assertion helpers shared by the packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HCBP_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hcbp assertion failed");

// Next-cycle implication, checked out of reset.
`define HCBP_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hcbp assertion failed");

`endif

### rtl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int MaxCodeLen  = 32;
  localparam int SymbolCount = 256;
  localparam int WordBits    = 32;
  localparam int QueueDepth  = 4;
  localparam logic [2:0] TopBit = 3'd7;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ENCODE  = 2'd0,
    KIND_MISSING = 2'd1,
    KIND_FLUSH   = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SHIFT = 1'b1
  } back_state_e;

  // One queued job: code is left aligned, len bits valid from the top.
  typedef struct packed {
    kind_e                kind;
    logic [WordBits-1:0]  code;
    logic [5:0]           len;
  } q_entry_t;

endpackage

### rtl/hcbp_front.sv
module hcbp_front #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLen,
  parameter int SYMBOL_COUNT = hcbp_pkg::SymbolCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [7:0]           symbol_i,
  input  logic [31:0]          code_word_i,
  input  logic [5:0]           code_length_i,
  input  logic                 room_i,
  output logic                 push_o,
  output hcbp_pkg::q_entry_t   entry_o
);

  localparam int IdxW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam logic [6:0] LenLimit =
    (MAX_CODE_LEN < hcbp_pkg::WordBits) ? 7'(MAX_CODE_LEN) : 7'(hcbp_pkg::WordBits);

  typedef struct packed {
    logic [5:0]  len;
    logic [31:0] word;
  } code_entry_t;

  code_entry_t              mem [SYMBOL_COUNT];
  code_entry_t              rd_q;
  logic [SYMBOL_COUNT-1:0]  valid_q;
  logic                     s1_valid_q;
  hcbp_pkg::kind_e          s1_kind_q;

  logic              accept;
  logic [IdxW-1:0]   idx;
  logic              in_range;
  logic              len_ok;
  logic              do_load;
  logic              do_read;
  logic              do_push;
  hcbp_pkg::kind_e   kind;

  assign in_ready_o = room_i;
  assign accept     = in_valid_i & room_i;
  assign idx        = symbol_i[IdxW-1:0];
  assign in_range   = ({1'b0, symbol_i} < 9'(SYMBOL_COUNT));
  assign len_ok     = ({1'b0, code_length_i} <= LenLimit);

  always_comb begin
    do_load = 1'b0;
    do_read = 1'b0;
    do_push = 1'b0;
    kind    = hcbp_pkg::KIND_FLUSH;
    unique case (hcbp_pkg::cmd_e'(command_i))
      hcbp_pkg::CMD_LOAD: begin
        do_load = accept & in_range & len_ok;
      end
      hcbp_pkg::CMD_ENCODE: begin
        do_push = accept;
        do_read = accept;
        kind    = (in_range && valid_q[idx]) ? hcbp_pkg::KIND_ENCODE
                                             : hcbp_pkg::KIND_MISSING;
      end
      hcbp_pkg::CMD_FLUSH: begin
        do_push = accept;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= do_push;
      if (do_load) begin
        valid_q[idx] <= 1'b1;
      end
    end
  end

  // code table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem[idx] <= '{len: code_length_i, word: code_word_i};
    end
    if (do_read) begin
      rd_q <= mem[idx];
    end
    if (do_push) begin
      s1_kind_q <= kind;
    end
  end

  assign push_o        = s1_valid_q;
  assign entry_o.kind  = s1_kind_q;
  assign entry_o.len   = rd_q.len;
  assign entry_o.code  = rd_q.word << (6'd32 - rd_q.len);

endmodule

### rtl/hcbp_fifo.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hcbp_pkg::q_entry_t  entry_i,
  input  logic                pop_i,
  output hcbp_pkg::q_entry_t  entry_o,
  output logic                empty_o,
  output logic                room_o
);

  localparam int PtrW = $clog2(hcbp_pkg::QueueDepth);
  localparam int CntW = PtrW + 1;

  hcbp_pkg::q_entry_t  slot_q [hcbp_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                full;

  assign full    = (cnt_q == CntW'(hcbp_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  // two free slots: one for the item in the front's read stage, one for a new one
  assign room_o  = (cnt_q <= CntW'(hcbp_pkg::QueueDepth - 2));
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  `HCBP_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full)
  `HCBP_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)
  `HCBP_ASSERT_NXT(a_push_fills, clk_i, rst_ni, push_i && !pop_i, !empty_o)

endmodule

### rtl/hcbp_back.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  hcbp_pkg::q_entry_t  entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          packed_byte_o,
  output logic                last_of_run_o,
  output logic                missing_code_o
);

  localparam int WB = hcbp_pkg::WordBits;

  hcbp_pkg::back_state_e  state_q, state_d;
  logic [WB-1:0]          word_q, word_d;
  logic [5:0]             rem_q, rem_d;
  logic [2:0]             pos_q, pos_d;
  logic [7:0]             part_q, part_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_miss_q;

  logic        out_free;
  logic [3:0]  free;
  logic        rem_small;
  logic [3:0]  k;
  logic [7:0]  chunk;
  logic [5:0]  rem_next;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_miss;

  assign out_free  = !out_valid_q || out_ready_i;
  assign free      = {1'b0, pos_q} + 4'd1;
  assign rem_small = (rem_q < {2'b00, free});
  assign k         = rem_small ? rem_q[3:0] : free;
  // bits below the remaining length are zero, so no mask is needed
  assign chunk     = word_q[WB-1 -: 8] >> (3'd7 - pos_q);
  assign rem_next  = rem_q - {2'b00, k};

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    part_d    = part_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    emit_miss = 1'b0;
    unique case (state_q)
      hcbp_pkg::ST_IDLE: begin
        if (!empty_i) begin
          case (entry_i.kind)
            hcbp_pkg::KIND_ENCODE: begin
              pop_o = 1'b1;
              if (entry_i.len != '0) begin
                word_d  = entry_i.code;
                rem_d   = entry_i.len;
                state_d = hcbp_pkg::ST_SHIFT;
              end
            end
            hcbp_pkg::KIND_MISSING: begin
              if (out_free) begin
                pop_o     = 1'b1;
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_miss = 1'b1;
              end
            end
            hcbp_pkg::KIND_FLUSH: begin
              if (pos_q != hcbp_pkg::TopBit) begin
                if (out_free) begin
                  pop_o     = 1'b1;
                  emit      = 1'b1;
                  emit_byte = part_q;
                  emit_last = 1'b1;
                  part_d    = '0;
                  pos_d     = hcbp_pkg::TopBit;
                end
              end else begin
                pop_o = 1'b1;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      hcbp_pkg::ST_SHIFT: begin
        if (rem_small || out_free) begin
          word_d = word_q << k;
          rem_d  = rem_next;
          if (!rem_small) begin
            emit      = 1'b1;
            emit_byte = part_q | chunk;
            emit_last = (rem_next < 6'd8);
            part_d    = '0;
            pos_d     = hcbp_pkg::TopBit;
          end else begin
            part_d = part_q | chunk;
            pos_d  = pos_q - k[2:0];
          end
          if (rem_next == '0) begin
            state_d = hcbp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = hcbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hcbp_pkg::ST_IDLE;
      rem_q       <= '0;
      pos_q       <= hcbp_pkg::TopBit;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      part_q  <= part_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
      out_miss_q <= emit_miss;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_byte_o  = out_byte_q;
  assign last_of_run_o  = out_last_q;
  assign missing_code_o = out_miss_q;

  `HCBP_ASSERT_IMP(a_shift_has_bits, clk_i, rst_ni, state_q == hcbp_pkg::ST_SHIFT,
                   rem_q != '0)
  `HCBP_ASSERT_IMP(a_empty_byte_clear, clk_i, rst_ni, pos_q == hcbp_pkg::TopBit,
                   part_q == '0)

endmodule

### rtl/huffman_code_bit_packer.sv
// Huffman encoder with a loadable code table and an MSB-first byte packer.
// Input stream (s_axis_*): tuser carries the command (load, encode, flush);
// tdata carries symbol, code word and code length. A load writes one table
// entry and gives no output; an encode emits every byte it completes; a flush
// emits the zero-padded partial byte, if any, and restarts the packer.
// Output stream (m_axis_*): one byte per transfer, tlast on the final byte an
// input caused, tuser set on the single result of an encode with no code.
// A missing-code or flush result passes the front's read register, the
// queue and the output register; an encode's first byte also waits for the
// back end to take the job from the queue into its shift state. There it adds
// the code to the partial byte a piece at a time, each piece filling the byte
// or ending the code, and emits each byte it completes; loads stay in the
// front and never reach the queue.
// Reset clears every table valid bit at once (table data needs no clearing)
// and empties the packer. When the receiver stalls, the output register holds
// its byte and the back end stops at the next byte it would emit; once the
// four-entry queue holds three jobs s_axis_tready drops, the last free slot
// taking the job still in the front's read stage.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLen,
  parameter int SYMBOL_COUNT = hcbp_pkg::SymbolCount
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // symbol[7:0], code_word[39:8], code_length[45:40], 0
  input  logic [1:0]   s_axis_tuser,   // command[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // packed_byte[7:0]
  output logic         m_axis_tlast,   // last_of_run
  output logic         m_axis_tuser    // missing_code[0]
);

  logic                push;
  logic                pop;
  logic                room;
  logic                empty;
  hcbp_pkg::q_entry_t  push_entry;
  hcbp_pkg::q_entry_t  head_entry;

  // front: decode commands, own the code table, classify encodes
  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .command_i     (s_axis_tuser),
    .symbol_i      (s_axis_tdata[7:0]),
    .code_word_i   (s_axis_tdata[39:8]),
    .code_length_i (s_axis_tdata[45:40]),
    .room_i        (room),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  // job queue between the two halves
  hcbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty),
    .room_o  (room)
  );

  // back: bit packer plus output register
  hcbp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .packed_byte_o  (m_axis_tdata),
    .last_of_run_o  (m_axis_tlast),
    .missing_code_o (m_axis_tuser)
  );

endmodule

### bench/huffman_code_bit_packer_test.sv
`timescale 1ns / 1ps

// Bench for the Huffman code packer. Items are built up front into a queue.
// A clocked driver sends them on the input stream. A clocked monitor checks
// every output transfer against a byte-level prediction of the packer.
module huffman_code_bit_packer_test;

  // tuser value that the block has no command for; it must be dropped
  localparam logic [1:0] CmdReserved = 2'd3;
  localparam int RandomItems = 285;
  localparam int DrainCycles = 12;       // drain time after the last predicted byte
  localparam int TimeoutNs   = 2_000_000;

  // Idle profile; the index runs with the item count through the random part
  typedef enum int {
    PH_STEADY,          // no idling on either side
    PH_SLOW_SENDER,     // sender idles with an 87 percent chance
    PH_SLOW_RECEIVER,   // receiver stalls with an 87 percent chance
    PH_BOTH_IDLE        // each side idles with a 32 percent chance
  } phase_e;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic [31:0] word;
    logic [5:0]  len;
    phase_e      phase;
  } pack_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       miss;
  } packed_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // symbol[7:0], code_word[39:8], code_length[45:40], 0
  logic [1:0]  s_tuser = '0;    // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // packed_byte[7:0]
  logic        m_tlast;         // last_of_run
  logic        m_tuser;         // missing_code[0]

  huffman_code_bit_packer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Packer prediction: its own code table plus the partially filled byte.
  // ---------------------------------------------------------------------------
  logic [31:0] code_tbl_word [hcbp_pkg::SymbolCount];
  logic [5:0]  code_tbl_len [hcbp_pkg::SymbolCount];
  bit          code_tbl_valid [hcbp_pkg::SymbolCount];   // all clear out of reset
  logic [7:0]  fill_byte = '0;
  logic [2:0]  fill_pos = hcbp_pkg::TopBit;              // next bit to write, counts down

  packed_out_t expected_bytes[$];
  pack_item_t  pending_items[$];
  pack_item_t  cur_item;
  phase_e      rx_phase = PH_STEADY;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          bytes_checked = 0;
  int          missing_seen = 0;

  task automatic apply_command(input pack_item_t it);
    int emitted;
    int n;
    emitted = 0;
    case (it.cmd)
      hcbp_pkg::CMD_LOAD: begin
        // overlong codes leave the entry untouched
        if (int'(it.sym) < hcbp_pkg::SymbolCount && it.len <= hcbp_pkg::MaxCodeLen &&
            it.len <= hcbp_pkg::WordBits) begin
          code_tbl_word[it.sym]  = it.word;
          code_tbl_len[it.sym]   = it.len;
          code_tbl_valid[it.sym] = 1'b1;
        end
      end
      hcbp_pkg::CMD_ENCODE: begin
        if (int'(it.sym) >= hcbp_pkg::SymbolCount || !code_tbl_valid[it.sym]) begin
          // single error result, packer state kept
          expected_bytes.push_back('{data: 8'h00, last: 1'b1, miss: 1'b1});
        end else begin
          n = code_tbl_len[it.sym];
          // first code bit is the top used bit of the right-aligned word
          for (int i = n - 1; i >= 0; i--) begin
            if (code_tbl_word[it.sym][i]) fill_byte[fill_pos] = 1'b1;
            if (fill_pos == 3'd0) begin
              expected_bytes.push_back('{data: fill_byte, last: 1'b0, miss: 1'b0});
              emitted++;
              fill_byte = '0;
              fill_pos  = hcbp_pkg::TopBit;
            end else begin
              fill_pos = fill_pos - 3'd1;
            end
          end
          if (emitted > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        end
      end
      hcbp_pkg::CMD_FLUSH: begin
        // an empty packer gives nothing, but is restarted either way
        if (fill_pos != hcbp_pkg::TopBit)
          expected_bytes.push_back('{data: fill_byte, last: 1'b1, miss: 1'b0});
        fill_byte = '0;
        fill_pos  = hcbp_pkg::TopBit;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic bit idles(input phase_e ph, input bit receiver_side);
    int roll;
    roll = $urandom_range(99);
    case (ph)
      PH_SLOW_SENDER:   return !receiver_side && roll < 87;
      PH_SLOW_RECEIVER: return receiver_side && roll < 87;
      PH_BOTH_IDLE:     return roll < 32;
      default:          return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predicts on each accepted transfer, then offers the next item.
  // tvalid gets at most one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_command(cur_item);
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && !idles(pending_items[0].phase, 1'b0)) begin
          cur_item = pending_items.pop_front();
          rx_phase = cur_item.phase;
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, cur_item.len, cur_item.word, cur_item.sym};
          s_tuser  <= cur_item.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: field-by-field compare against the oldest predicted byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    packed_out_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer data=%02h last=%b miss=%b",
                                    m_tdata, m_tlast, m_tuser));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (want.miss) missing_seen++;
          if (m_tdata !== want.data)
            report_mismatch($sformatf("packed byte %02h, want %02h", m_tdata, want.data));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
          if (m_tuser !== want.miss)
            report_mismatch($sformatf("missing flag %b, want %b", m_tuser, want.miss));
        end
      end
      m_tready <= !idles(rx_phase, 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  bit         gen_loaded [hcbp_pkg::SymbolCount];
  logic [7:0] gen_loaded_list[$];   // symbols that have an accepted code

  function automatic pack_item_t make_item(input logic [1:0] c, input logic [7:0] s,
                                           input logic [31:0] w, input logic [5:0] l,
                                           input phase_e ph);
    return '{cmd: c, sym: s, word: w, len: l, phase: ph};
  endfunction

  task automatic enqueue(input pack_item_t it);
    if (it.cmd == hcbp_pkg::CMD_LOAD && it.len <= hcbp_pkg::MaxCodeLen &&
        !gen_loaded[it.sym]) begin
      gen_loaded[it.sym] = 1'b1;
      gen_loaded_list.push_back(it.sym);
    end
    pending_items.push_back(it);
  endtask

  initial begin
    int          roll;
    int          lroll;
    phase_e      ph;
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic [31:0] word;
    logic [5:0]  len;

    // Directed part, no idling
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h00, 32'h0, 6'd0, PH_STEADY)); // code not loaded
    enqueue(make_item(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0, PH_STEADY));  // nothing pending
    enqueue(make_item(CmdReserved, 8'hFF, 32'hFFFF_FFFF, 6'd63, PH_STEADY));
    // zero-length code, then an encode that adds no bits
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h00, 32'h0, 6'd0, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'hFF, 32'h0, 6'd33, PH_STEADY)); // overlong
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'hFF, 32'h0, 6'd63, PH_STEADY)); // overlong
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'hFF, 32'h0, 6'd0, PH_STEADY)); // four bytes
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'h01, 32'h1, 6'd1, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h01, 32'h0, 6'd0, PH_STEADY)); // partial only
    enqueue(make_item(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0, PH_STEADY));  // padded byte
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'h02, 32'hA5C3_0F81, 6'd32, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h01, 32'h0, 6'd0, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h02, 32'h0, 6'd0, PH_STEADY)); // unaligned 32
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'h03, 32'h0000_007F, 6'd7, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h03, 32'h0, 6'd0, PH_STEADY)); // closes a byte
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'h80, 32'h0, 6'd8, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h80, 32'h0, 6'd0, PH_STEADY)); // aligned zero
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'h55, 32'h2AAA_AAAA, 6'd31, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'h55, 32'h0, 6'd0, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_LOAD, 8'hAA, 32'h0, 6'd32, PH_STEADY));
    enqueue(make_item(hcbp_pkg::CMD_ENCODE, 8'hAA, 32'h0, 6'd0, PH_STEADY)); // aligned end
    enqueue(make_item(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0, PH_STEADY));

    // Random part: mostly encodes of loaded symbols with short codes, plus
    // reloads, rejected loads, unloaded symbols, flushes and the spare command.
    for (int n = 0; n < RandomItems; n++) begin
      ph    = phase_e'(n * 4 / RandomItems);
      roll  = $urandom_range(99);
      sym   = 8'($urandom_range(255));
      word  = $urandom();
      len   = 6'($urandom_range(63));
      if (roll < 22) begin
        cmd   = hcbp_pkg::CMD_LOAD;
        lroll = $urandom_range(99);
        if (lroll < 5)       len = 6'd0;
        else if (lroll < 12) len = 6'($urandom_range(63, 33));
        else if (lroll < 22) len = 6'($urandom_range(32, 25));
        else                 len = 6'($urandom_range(12, 1));
      end else if (roll < 88) begin
        cmd = hcbp_pkg::CMD_ENCODE;
        if (gen_loaded_list.size() > 0 && $urandom_range(9) != 0)
          sym = gen_loaded_list[$urandom_range(gen_loaded_list.size() - 1)];
      end else if (roll < 97) begin
        cmd = hcbp_pkg::CMD_FLUSH;
      end else begin
        cmd = CmdReserved;
      end
      enqueue(make_item(cmd, sym, word, len, ph));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all items sent and every predicted byte seen, then a short drain
    @(negedge clk_i);
    while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d predicted bytes never arrived", expected_bytes.size()));

    $display("sent %0d commands (directed, then random across four idle profiles)",
             items_sent);
    $display("checked %0d output transfers, %0d of them missing-code errors; %0d mismatches",
             bytes_checked, missing_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #TimeoutNs;
    $display("timeout: stream stalled with %0d commands queued, %0d bytes outstanding",
             pending_items.size(), expected_bytes.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/hcbp_pkg.sv
rtl/hcbp_front.sv
rtl/hcbp_fifo.sv
rtl/hcbp_back.sv
rtl/huffman_code_bit_packer.sv
bench/huffman_code_bit_packer_test.sv
